### hw/rtl/rvx_pkg.sv
// Shared types and constants for the RV32 subset execute step.
package rvx_pkg;

   localparam logic [31:0] RESET_PC_DEFAULT = 32'h8000_0000;
   localparam logic [31:0] JALR_MASK        = ~32'd1;
   localparam logic [31:0] EBREAK_WORD      = 32'h0010_0073;
   localparam logic [4:0]  HALT_REG         = 5'd10;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_BRANCH = 7'h63;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_HALF = 3'd1;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_SUB  = 7'h20;
   localparam logic [6:0] F7_MUL  = 7'h01;

   localparam logic [1:0] MOP_NONE  = 2'd0;
   localparam logic [1:0] MOP_READ  = 2'd1;
   localparam logic [1:0] MOP_WRITE = 2'd2;

   localparam logic [1:0] ST_RUN     = 2'd0;
   localparam logic [1:0] ST_WAIT    = 2'd1;
   localparam logic [1:0] ST_HALT    = 2'd2;
   localparam logic [1:0] ST_ILLEGAL = 2'd3;

   localparam logic [3:0] STRB_WORD = 4'hf;
   localparam logic [3:0] STRB_HI   = 4'hc;
   localparam logic [3:0] STRB_LO   = 4'h3;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_REM
   } fsm_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] value;
   } rem_rsp_type;

endpackage

### hw/rtl/rvx_rem.sv
// Iterative signed remainder unit, one quotient bit per cycle.
module rvx_rem (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        dividend,
   input  logic [31:0]        divisor,
   output rvx_pkg::rem_rsp_type rsp
);
   import rvx_pkg::*;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [31:0] val_ff, val_in;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic [31:0] rem_step;

   assign shifted  = {rem_ff, dvd_ff[31]};
   assign diff     = {1'b0, shifted} - {2'b00, dvs_ff};
   assign rem_step = diff[33] ? shifted[31:0] : diff[31:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      val_in  = val_ff;
      if (start) begin
         neg_in = dividend[31];
         dvd_in = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in = divisor[31] ? (32'd0 - divisor) : divisor;
         rem_in = 32'd0;
         cnt_in = 5'd31;
         if (divisor == 32'd0) begin
            busy_in = 1'b0;
            val_in  = dividend;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            val_in  = neg_ff ? (32'd0 - rem_step) : rem_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      val_ff <= val_in;
   end

   assign rsp.busy  = busy_ff;
   assign rsp.value = val_ff;

endmodule

### hw/rtl/rv32_subset_execute_step.sv
// Top level: RV32 subset execute step with register file memories and pc.
// Flow: a request is registered with its register file read; then it executes and
// commits into the response registers, rem first waiting on the remainder unit.
// A new request is stalled until the previous one has committed; a zero divisor
// makes the bit-serial remainder unit finish without iterating.
// Reset: pc loads reset_pc in the cycle after reset (request stalled then);
// register file reads zero until written, no load pending.
module rv32_subset_execute_step #(
   parameter int REG_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic [1:0]  rsp_mem_op,
   output logic [31:0] rsp_mem_addr,
   output logic [31:0] rsp_mem_wdata,
   output logic [3:0]  rsp_mem_strobe,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_halt_code
);
   import rvx_pkg::*;

   localparam int AW = $clog2(REG_COUNT);

   fsm_type state_ff, state_in;

   logic [31:0] reset_pc_ff;
   logic        boot_ff;
   logic [31:0] pc_ff, pc_in;
   logic        load_pend_ff, load_pend_in;
   logic [4:0]  load_dest_ff, load_dest_in;
   logic [REG_COUNT-1:0] vld_ff;

   logic [31:0] mem_a [REG_COUNT];
   logic [31:0] mem_b [REG_COUNT];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic        a_ok_ff, b_ok_ff;

   logic        action_ff;
   logic [31:0] instr_ff;
   logic [31:0] ldata_ff;

   logic        accept, commit, out_free, rem_op, rem_start;
   logic [4:0]  ra, rb;
   rem_rsp_type rem_rsp;

   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] a, b, immi, imms, immu, immb, immj, ad;

   logic [31:0] npc_in, addr_in, wdata_in, wval, halt_in;
   logic [1:0]  mop_in, stat_in;
   logic [3:0]  strb_in;
   logic        wen;
   logic [4:0]  widx;
   logic        wr_ok;

   logic        rsp_valid_ff;
   logic [31:0] npc_ff, addr_ff, wdata_ff, rval_ff, halt_ff;
   logic [1:0]  mop_ff, stat_ff;
   logic [3:0]  strb_ff;
   logic        rw_ff;
   logic [4:0]  ridx_ff;

   assign req_stall = (state_ff != FSM_IDLE) || boot_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign ra = (req_instr_word == EBREAK_WORD) ? HALT_REG : req_instr_word[19:15];
   assign rb = req_instr_word[24:20];

   assign opc  = instr_ff[6:0];
   assign f3   = instr_ff[14:12];
   assign f7   = instr_ff[31:25];
   assign rd   = instr_ff[11:7];
   assign a    = a_ok_ff ? rd_a_ff : 32'd0;
   assign b    = b_ok_ff ? rd_b_ff : 32'd0;
   assign immi = {{20{instr_ff[31]}}, instr_ff[31:20]};
   assign imms = {{20{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
   assign immu = {instr_ff[31:12], 12'd0};
   assign immb = {{20{instr_ff[31]}}, instr_ff[7], instr_ff[30:25], instr_ff[11:8], 1'b0};
   assign immj = {{12{instr_ff[31]}}, instr_ff[19:12], instr_ff[20],
                  instr_ff[30:21], 1'b0};

   assign rem_op = !action_ff && !load_pend_ff && (opc == OPC_OP) && (f7 == F7_MUL)
                   && (f3 == F3_OR);

   rvx_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (a),
      .divisor  (b),
      .rsp      (rem_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (rem_op) state_in = FSM_REM;
            else if (commit) state_in = FSM_IDLE;
         end
         FSM_REM: begin
            if (commit) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      rem_start = (state_ff == FSM_EXEC) && rem_op;
      commit    = out_free && (((state_ff == FSM_EXEC) && !rem_op)
                  || ((state_ff == FSM_REM) && !rem_rsp.busy));
   end

   always_comb begin
      npc_in       = pc_ff + 32'd4;
      mop_in       = MOP_NONE;
      addr_in      = 32'd0;
      wdata_in     = 32'd0;
      strb_in      = 4'd0;
      wen          = 1'b0;
      widx         = rd;
      wval         = 32'd0;
      stat_in      = ST_RUN;
      halt_in      = 32'd0;
      load_pend_in = load_pend_ff;
      load_dest_in = load_dest_ff;
      ad           = a + imms;
      if (action_ff) begin
         npc_in = pc_ff;
         if (load_pend_ff) begin
            wen          = 1'b1;
            widx         = load_dest_ff;
            wval         = ldata_ff;
            load_pend_in = 1'b0;
         end
      end else if (load_pend_ff) begin
         npc_in  = pc_ff;
         stat_in = ST_WAIT;
      end else if (opc == OPC_LUI) begin
         wen = 1'b1; wval = immu;
      end else if (opc == OPC_AUIPC) begin
         wen = 1'b1; wval = pc_ff + immu;
      end else if (opc == OPC_LOAD && f3 == F3_WORD) begin
         mop_in       = MOP_READ;
         addr_in      = a + immi;
         load_pend_in = 1'b1;
         load_dest_in = rd;
         stat_in      = ST_WAIT;
      end else if (opc == OPC_STORE && (f3 == F3_WORD || f3 == F3_HALF)) begin
         mop_in  = MOP_WRITE;
         addr_in = ad;
         if (f3 == F3_WORD) begin
            wdata_in = b;
            strb_in  = STRB_WORD;
         end else if (ad[1]) begin
            wdata_in = {b[15:0], 16'd0};
            strb_in  = STRB_HI;
         end else begin
            wdata_in = {16'd0, b[15:0]};
            strb_in  = STRB_LO;
         end
      end else if (opc == OPC_OPIMM && f3 == F3_ADD) begin
         wen = 1'b1; wval = a + immi;
      end else if (opc == OPC_OPIMM && f3 == F3_SLTU) begin
         wen = 1'b1; wval = {31'd0, a < immi};
      end else if (opc == OPC_OPIMM && f3 == F3_AND) begin
         wen = 1'b1; wval = a & immi;
      end else if (opc == OPC_OPIMM && f3 == F3_SLL && f7 == F7_BASE) begin
         wen = 1'b1; wval = a << immi[4:0];
      end else if (opc == OPC_JALR && f3 == F3_ADD) begin
         npc_in = (a + immi) & JALR_MASK;
         wen = 1'b1; wval = pc_ff + 32'd4;
      end else if (opc == OPC_JAL) begin
         npc_in = pc_ff + immj;
         wen = 1'b1; wval = pc_ff + 32'd4;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_ADD) begin
         wen = 1'b1; wval = a + b;
      end else if (opc == OPC_OP && f7 == F7_SUB && f3 == F3_ADD) begin
         wen = 1'b1; wval = a - b;
      end else if (opc == OPC_OP && f7 == F7_MUL && f3 == F3_OR) begin
         wen = 1'b1; wval = rem_rsp.value;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_XOR) begin
         wen = 1'b1; wval = a ^ b;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_OR) begin
         wen = 1'b1; wval = a | b;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_SLTU) begin
         wen = 1'b1; wval = {31'd0, a < b};
      end else if (opc == OPC_BRANCH && f3 == F3_BEQ) begin
         if (a == b) npc_in = pc_ff + immb;
      end else if (opc == OPC_BRANCH && f3 == F3_BNE) begin
         if (a != b) npc_in = pc_ff + immb;
      end else if (opc == OPC_BRANCH && f3 == F3_BLT) begin
         if ($signed(a) < $signed(b)) npc_in = pc_ff + immb;
      end else if (instr_ff == EBREAK_WORD) begin
         npc_in  = pc_ff;
         stat_in = ST_HALT;
         halt_in = a;
      end else begin
         npc_in  = pc_ff;
         stat_in = ST_ILLEGAL;
      end
      wr_ok = wen && (widx != 5'd0) && (int'(widx) < REG_COUNT);
      pc_in = boot_ff ? reset_pc_ff : (commit ? npc_in : pc_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_ok && commit) begin
         mem_a[widx[AW-1:0]] <= wval;
      end
      if (accept) begin
         rd_a_ff <= mem_a[ra[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok && commit) begin
         mem_b[widx[AW-1:0]] <= wval;
      end
      if (accept) begin
         rd_b_ff <= mem_b[rb[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         reset_pc_ff  <= RESET_PC_DEFAULT;
         boot_ff      <= 1'b1;
         pc_ff        <= RESET_PC_DEFAULT;
         load_pend_ff <= 1'b0;
         load_dest_ff <= 5'd0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) reset_pc_ff <= csr_wr_data;
         boot_ff <= 1'b0;
         pc_ff   <= pc_in;
         if (commit) begin
            load_pend_ff <= load_pend_in;
            load_dest_ff <= load_dest_in;
            if (wr_ok) vld_ff[widx[AW-1:0]] <= 1'b1;
         end
         if (commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         instr_ff  <= req_instr_word;
         ldata_ff  <= req_load_data;
         a_ok_ff   <= (int'(ra) < REG_COUNT) && vld_ff[ra[AW-1:0]];
         b_ok_ff   <= (int'(rb) < REG_COUNT) && vld_ff[rb[AW-1:0]];
      end
      if (commit) begin
         npc_ff   <= npc_in;
         mop_ff   <= mop_in;
         addr_ff  <= addr_in;
         wdata_ff <= wdata_in;
         strb_ff  <= strb_in;
         rw_ff    <= wr_ok;
         ridx_ff  <= wr_ok ? widx : 5'd0;
         rval_ff  <= wr_ok ? wval : 32'd0;
         stat_ff  <= stat_in;
         halt_ff  <= halt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = npc_ff;
   assign rsp_mem_op     = mop_ff;
   assign rsp_mem_addr   = addr_ff;
   assign rsp_mem_wdata  = wdata_ff;
   assign rsp_mem_strobe = strb_ff;
   assign rsp_reg_write  = rw_ff;
   assign rsp_reg_index  = ridx_ff;
   assign rsp_reg_value  = rval_ff;
   assign rsp_status     = stat_ff;
   assign rsp_halt_code  = halt_ff;

endmodule

### hw/rtl/rvx_chk.sv
// Port checker for the RV32 subset execute step, bound to the top level.
module rvx_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_mem_op,
   input logic [3:0]  rsp_mem_strobe,
   input logic        rsp_reg_write,
   input logic [4:0]  rsp_reg_index,
   input logic [1:0]  rsp_status
);
   import rvx_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("response valid or request open right after reset");

   a_no_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> rsp_reg_index != 5'd0)
      else $error("write reported to x0");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_op != MOP_WRITE |-> rsp_mem_strobe == 4'd0)
      else $error("byte strobes without a write");

   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_op == MOP_READ |-> rsp_status == ST_WAIT)
      else $error("read issued without wait status");

endmodule

bind rv32_subset_execute_step rvx_chk u_rvx_chk (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_mem_op     (rsp_mem_op),
   .rsp_mem_strobe (rsp_mem_strobe),
   .rsp_reg_write  (rsp_reg_write),
   .rsp_reg_index  (rsp_reg_index),
   .rsp_status     (rsp_status)
);
